// File: rtl/partition_header_checker_core_defines.svh
// assertion macros shared by the checker rtl
`ifndef PARTITION_HEADER_CHECKER_CORE_DEFINES_SVH
`define PARTITION_HEADER_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PHC_ASSERT_IMPL(LABEL, CLK, RST, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error(MSG);

// next-cycle implication, disabled during reset
`define PHC_ASSERT_NEXT(LABEL, CLK, RST, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

// File: rtl/phc_pkg.sv
`default_nettype none
package phc_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int HALF_W      = 16;
  localparam int POS_W       = 11;
  localparam int ASM_W       = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int TDATA_W     = 320;
  localparam int TUSER_W     = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MBR_TYPE = 1'd1;

  localparam logic [WORD_W-1:0] MAGIC_RESET    = 32'h0041_5041;
  localparam logic [HALF_W-1:0] MBR_TYPE_RESET = 16'd1;

  // word index (byte offset / 4) of each captured word
  localparam logic [7:0] WI_STORED    = 8'd0;
  localparam logic [7:0] WI_MAGIC     = 8'd1;
  localparam logic [7:0] WI_NEXT      = 8'd2;
  localparam logic [7:0] WI_PREV      = 8'd3;
  localparam logic [7:0] WI_START     = 8'd16;
  localparam logic [7:0] WI_LENGTH    = 8'd17;
  localparam logic [7:0] WI_TYPE      = 8'd18;
  localparam logic [7:0] WI_SUB       = 8'd19;
  localparam logic [7:0] WI_OSD_START = 8'd76;
  localparam logic [7:0] WI_OSD_SIZE  = 8'd77;

  // byte 16..21 holds the id, bytes 256..287 the signature
  localparam logic [6:0] ID_BLOCK  = 7'd2;
  localparam logic [2:0] ID_LEN    = 3'd6;
  localparam logic [4:0] SIG_BLOCK = 5'd8;

  localparam logic [BYTE_W-1:0] ID_PATTERN [6] = '{
    8'h5F, 8'h5F, 8'h6D, 8'h62, 8'h72, 8'h00
  };

  localparam logic [BYTE_W-1:0] SIG_PATTERN [32] = '{
    8'h53, 8'h6F, 8'h6E, 8'h79, 8'h20, 8'h43, 8'h6F, 8'h6D,
    8'h70, 8'h75, 8'h74, 8'h65, 8'h72, 8'h20, 8'h45, 8'h6E,
    8'h74, 8'h65, 8'h72, 8'h74, 8'h61, 8'h69, 8'h6E, 8'h6D,
    8'h65, 8'h6E, 8'h74, 8'h20, 8'h49, 8'h6E, 8'h63, 8'h2E
  };

  typedef enum logic [2:0] {
    STATUS_VALID      = 3'd0,
    STATUS_INCOMPLETE = 3'd1,
    STATUS_NO_MAGIC   = 3'd2,
    STATUS_BAD_SUM    = 3'd3,
    STATUS_BAD_MBR    = 3'd4
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] magic_word;
    logic [HALF_W-1:0] mbr_type_code;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              check_mbr;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] stored_sum;
    logic [WORD_W-1:0] computed_sum;
    logic [WORD_W-1:0] next_sector;
    logic [WORD_W-1:0] previous_sector;
    logic [WORD_W-1:0] start_sector;
    logic [WORD_W-1:0] length_sectors;
    logic [HALF_W-1:0] part_type;
    logic [HALF_W-1:0] part_flags;
    logic [WORD_W-1:0] sub_count;
    logic [WORD_W-1:0] osd_start_sector;
    logic [WORD_W-1:0] osd_size_sectors;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/partition_header_checker_core.sv
// Partition header checker: takes a 1024-byte partition header one byte per item on the
// slave stream, sums its little-endian words from offset 4 to 1020 with 32-bit wrap,
// captures the link, size, type and OSD words, and on the item flagged tlast gives one
// result item carrying a status (valid, incomplete, no magic, bad checksum, invalid MBR)
// and the captured words; status incomplete or no magic comes with all data zero. Bytes
// past the 1024th are dropped, though their tlast still ends the header. The block takes
// one byte every cycle unless stalled; a result passes the input and result registers
// to the master side. The only stall is a last byte held in the input register while
// the result register still holds an untaken result. The user writes the expected magic
// word and MBR type code on the cfg port while no header is in progress; not enforced.
`default_nettype none
`include "partition_header_checker_core_defines.svh"
module partition_header_checker_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [phc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [phc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // header bytes
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [phc_pkg::BYTE_W-1:0]        s_tdata,   // byte_value
  input  wire logic                              s_tuser,   // check_mbr
  input  wire logic                              s_tlast,   // last_byte
  // results
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // stored_sum, computed_sum, next_sector, previous_sector, start_sector,
  // length_sectors, part_type, part_flags, sub_count, osd_start_sector,
  // osd_size_sectors
  output logic [phc_pkg::TDATA_W-1:0]            m_tdata,
  output logic [phc_pkg::TUSER_W-1:0]            m_tuser    // status
);

  phc_pkg::cfg_t    cfg;
  phc_pkg::item_t   in_item;
  phc_pkg::result_t result_comb;
  phc_pkg::result_t result_q;
  logic             in_valid;
  logic             fire;
  logic             load;
  logic             out_free;

  // config registers, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word    <= phc_pkg::MAGIC_RESET;
      cfg.mbr_type_code <= phc_pkg::MBR_TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        phc_pkg::REG_MAGIC:    cfg.magic_word    <= cfg_data;
        phc_pkg::REG_MBR_TYPE: cfg.mbr_type_code <= cfg_data[phc_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: a plain byte always moves on, a last byte needs a free result slot
  assign fire     = in_valid && (!in_item.last_byte || out_free);
  assign load     = fire && in_item.last_byte;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.byte_value <= s_tdata;
      in_item.check_mbr  <= s_tuser;
      in_item.last_byte  <= s_tlast;
    end
  end

  // byte count, word sum, field capture and final checks
  phc_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (result_comb)
  );

  // result register
  phc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .result_in (result_comb),
    .ready     (m_tready),
    .valid     (m_tvalid),
    .free      (out_free),
    .result_q  (result_q)
  );

  assign m_tuser = result_q.status;
  assign m_tdata = {result_q.osd_size_sectors, result_q.osd_start_sector,
                    result_q.sub_count, result_q.part_flags, result_q.part_type,
                    result_q.length_sectors, result_q.start_sector,
                    result_q.previous_sector, result_q.next_sector,
                    result_q.computed_sum, result_q.stored_sum};

  // a short or unmatched header never leaks captured words
  `PHC_ASSERT_IMPL(a_fail_zero, clk, rst,
    m_tvalid && (m_tuser == phc_pkg::STATUS_INCOMPLETE ||
                 m_tuser == phc_pkg::STATUS_NO_MAGIC),
    m_tdata == '0, "failed header result carries nonzero data")
  // a result is only loaded into an empty or draining slot
  `PHC_ASSERT_IMPL(a_load_free, clk, rst, load, !m_tvalid || m_tready,
    "result overwritten before it was taken")
  // an accepted byte lands in the input register
  `PHC_ASSERT_NEXT(a_in_hold, clk, rst, s_tvalid && s_tready, in_valid,
    "accepted item lost from input register")

endmodule
`default_nettype wire

// File: rtl/phc_accum.sv
`default_nettype none
module phc_accum (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire phc_pkg::item_t item,
  input  wire phc_pkg::cfg_t  cfg,
  output phc_pkg::result_t    result
);

  logic [phc_pkg::POS_W-1:0]  pos, pos_next;
  logic [phc_pkg::ASM_W-1:0]  asm_word, asm_word_next;
  logic [phc_pkg::WORD_W-1:0] sum, sum_next;
  logic [phc_pkg::WORD_W-1:0] stored, stored_next;
  logic [phc_pkg::WORD_W-1:0] magic, magic_next;
  logic [phc_pkg::WORD_W-1:0] next_sec, next_sec_next;
  logic [phc_pkg::WORD_W-1:0] prev_sec, prev_sec_next;
  logic [phc_pkg::WORD_W-1:0] start, start_next;
  logic [phc_pkg::WORD_W-1:0] length, length_next;
  logic [phc_pkg::HALF_W-1:0] ptype, ptype_next;
  logic [phc_pkg::HALF_W-1:0] pflags, pflags_next;
  logic [phc_pkg::WORD_W-1:0] sub, sub_next;
  logic [phc_pkg::WORD_W-1:0] osd_start, osd_start_next;
  logic [phc_pkg::WORD_W-1:0] osd_size, osd_size_next;
  logic                       id_ok, id_ok_next;
  logic                       sig_ok, sig_ok_next;
  logic                       chk_mbr, chk_mbr_next;

  logic [phc_pkg::WORD_W-1:0] word;
  logic [7:0]                 widx;
  logic                       mbr_ok;

  assign word = {item.byte_value, asm_word};
  assign widx = pos[9:2];

  // state after taking this byte, before any end-of-header clear
  always_comb begin
    pos_next       = pos;
    asm_word_next  = asm_word;
    sum_next       = sum;
    stored_next    = stored;
    magic_next     = magic;
    next_sec_next  = next_sec;
    prev_sec_next  = prev_sec;
    start_next     = start;
    length_next    = length;
    ptype_next     = ptype;
    pflags_next    = pflags;
    sub_next       = sub;
    osd_start_next = osd_start;
    osd_size_next  = osd_size;
    id_ok_next     = id_ok;
    sig_ok_next    = sig_ok;
    chk_mbr_next   = chk_mbr;
    if (!pos[phc_pkg::POS_W-1]) begin
      pos_next = pos + 11'd1;
      if (pos == '0) begin
        chk_mbr_next = item.check_mbr;
      end
      if (pos[9:3] == phc_pkg::ID_BLOCK && pos[2:0] < phc_pkg::ID_LEN &&
          item.byte_value != phc_pkg::ID_PATTERN[pos[2:0]]) begin
        id_ok_next = 1'b0;
      end
      if (pos[9:5] == phc_pkg::SIG_BLOCK &&
          item.byte_value != phc_pkg::SIG_PATTERN[pos[4:0]]) begin
        sig_ok_next = 1'b0;
      end
      case (pos[1:0])
        2'd0: asm_word_next = {16'h0000, item.byte_value};
        2'd1: asm_word_next[15:8] = item.byte_value;
        2'd2: asm_word_next[23:16] = item.byte_value;
        default: begin
          asm_word_next = '0;
          if (widx != phc_pkg::WI_STORED) begin
            sum_next = sum + word;
          end
          case (widx)
            phc_pkg::WI_STORED:    stored_next    = word;
            phc_pkg::WI_MAGIC:     magic_next     = word;
            phc_pkg::WI_NEXT:      next_sec_next  = word;
            phc_pkg::WI_PREV:      prev_sec_next  = word;
            phc_pkg::WI_START:     start_next     = word;
            phc_pkg::WI_LENGTH:    length_next    = word;
            phc_pkg::WI_TYPE: begin
              ptype_next  = word[15:0];
              pflags_next = word[31:16];
            end
            phc_pkg::WI_SUB:       sub_next       = word;
            phc_pkg::WI_OSD_START: osd_start_next = word;
            phc_pkg::WI_OSD_SIZE:  osd_size_next  = word;
            default: ;
          endcase
        end
      endcase
    end
  end

  assign mbr_ok = id_ok_next && sig_ok_next && start_next == '0 &&
                  ptype_next == cfg.mbr_type_code;

  always_comb begin
    result        = '0;
    result.status = phc_pkg::STATUS_INCOMPLETE;
    if (!pos_next[phc_pkg::POS_W-1]) begin
      result.status = phc_pkg::STATUS_INCOMPLETE;
    end else if (magic_next != cfg.magic_word) begin
      result.status = phc_pkg::STATUS_NO_MAGIC;
    end else begin
      result.stored_sum       = stored_next;
      result.computed_sum     = sum_next;
      result.next_sector      = next_sec_next;
      result.previous_sector  = prev_sec_next;
      result.start_sector     = start_next;
      result.length_sectors   = length_next;
      result.part_type        = ptype_next;
      result.part_flags       = pflags_next;
      result.sub_count        = sub_next;
      result.osd_start_sector = osd_start_next;
      result.osd_size_sectors = osd_size_next;
      if (stored_next != sum_next) begin
        result.status = phc_pkg::STATUS_BAD_SUM;
      end else if (chk_mbr_next && !mbr_ok) begin
        result.status = phc_pkg::STATUS_BAD_MBR;
      end else begin
        result.status = phc_pkg::STATUS_VALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.last_byte)) begin
      pos       <= '0;
      asm_word  <= '0;
      sum       <= '0;
      stored    <= '0;
      magic     <= '0;
      next_sec  <= '0;
      prev_sec  <= '0;
      start     <= '0;
      length    <= '0;
      ptype     <= '0;
      pflags    <= '0;
      sub       <= '0;
      osd_start <= '0;
      osd_size  <= '0;
      id_ok     <= 1'b1;
      sig_ok    <= 1'b1;
      chk_mbr   <= 1'b1;
    end else if (fire) begin
      pos       <= pos_next;
      asm_word  <= asm_word_next;
      sum       <= sum_next;
      stored    <= stored_next;
      magic     <= magic_next;
      next_sec  <= next_sec_next;
      prev_sec  <= prev_sec_next;
      start     <= start_next;
      length    <= length_next;
      ptype     <= ptype_next;
      pflags    <= pflags_next;
      sub       <= sub_next;
      osd_start <= osd_start_next;
      osd_size  <= osd_size_next;
      id_ok     <= id_ok_next;
      sig_ok    <= sig_ok_next;
      chk_mbr   <= chk_mbr_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/phc_out_reg.sv
`default_nettype none
module phc_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire phc_pkg::result_t result_in,
  input  wire logic             ready,
  output logic                  valid,
  output logic                  free,
  output phc_pkg::result_t      result_q
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule
`default_nettype wire

// File: test/partition_header_checker_core_test.sv
`timescale 1ns / 100ps
module partition_header_checker_core_test;
  import phc_pkg::*;

  // header layout, byte offsets
  localparam int HDR_LEN       = 1024;
  localparam int OFS_STORED    = 0;
  localparam int OFS_MAGIC     = 4;
  localparam int OFS_NEXT      = 8;
  localparam int OFS_PREV      = 12;
  localparam int OFS_ID        = 16;
  localparam int ID_BYTES      = 6;
  localparam int OFS_START     = 64;
  localparam int OFS_LENGTH    = 68;
  localparam int OFS_TYPE      = 72;
  localparam int OFS_SUB       = 76;
  localparam int OFS_SIG       = 256;
  localparam int SIG_BYTES     = 32;
  localparam int OFS_OSD_START = 304;
  localparam int OFS_OSD_SIZE  = 308;

  localparam int NUM_PHASES     = 5;
  localparam int RANDOM_HEADERS = 5;    // short headers per phase
  localparam int FULL_PHASE     = 3;    // phase that carries the full header
  localparam int LONG_HOLD      = 2000; // receiver hold-off, cycles
  localparam int DRAIN_CYCLES   = 8;
  localparam int STALL_LIMIT    = 20000;

  typedef enum {
    HDR_SHORT, HDR_GOOD, HDR_MBR, HDR_BAD_MAGIC, HDR_BAD_SUM,
    HDR_BAD_ID, HDR_BAD_SIG, HDR_BAD_START, HDR_BAD_TYPE
  } hdr_kind_t;

  typedef enum { FILL_RANDOM, FILL_ZERO, FILL_ONES } fill_t;

  typedef enum { RX_FREE, RX_COIN, RX_SLOW } rx_mode_t;

  // running model of the checker plus the queue of results it predicts
  class header_scoreboard;
    logic [WORD_W-1:0] magic_word;
    logic [HALF_W-1:0] mbr_type;
    logic [10:0]       pos;
    logic [23:0]       low_bytes;
    logic [WORD_W-1:0] word_sum;
    logic [WORD_W-1:0] stored, magic_seen, next_s, prev_s, start_s, length_s;
    logic [WORD_W-1:0] sub_s, osd_start_s, osd_size_s;
    logic [HALF_W-1:0] ptype, pflags;
    bit                id_ok, sig_ok, chk;
    result_t           expected_q[$];
    int unsigned       fail_count;

    function new();
      magic_word = MAGIC_RESET;
      mbr_type   = MBR_TYPE_RESET;
      fail_count = 0;
      clear();
    endfunction

    function void clear();
      pos = '0;
      low_bytes = '0;
      word_sum = '0;
      {stored, magic_seen, next_s, prev_s, start_s, length_s} = '0;
      {sub_s, osd_start_s, osd_size_s, ptype, pflags} = '0;
      id_ok = 1'b1;
      sig_ok = 1'b1;
      chk = 1'b1;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAGIC:    magic_word = data;
        REG_MBR_TYPE: mbr_type = data[HALF_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, bit c);
      logic [WORD_W-1:0] word;
      int unsigned p;
      p = pos;
      if (p == 0) chk = c;
      if (p >= OFS_ID && p < OFS_ID + ID_BYTES && b != ID_PATTERN[p - OFS_ID]) id_ok = 1'b0;
      if (p >= OFS_SIG && p < OFS_SIG + SIG_BYTES && b != SIG_PATTERN[p - OFS_SIG])
        sig_ok = 1'b0;
      case (pos[1:0])
        2'd0: low_bytes = {16'h0, b};
        2'd1: low_bytes[15:8] = b;
        2'd2: low_bytes[23:16] = b;
        default: begin
          word = {b, low_bytes};
          // the stored checksum word itself is not part of the sum
          if (p - 3 >= OFS_MAGIC) word_sum = word_sum + word;
          case (p - 3)
            OFS_STORED:    stored = word;
            OFS_MAGIC:     magic_seen = word;
            OFS_NEXT:      next_s = word;
            OFS_PREV:      prev_s = word;
            OFS_START:     start_s = word;
            OFS_LENGTH:    length_s = word;
            OFS_TYPE:      {pflags, ptype} = word;
            OFS_SUB:       sub_s = word;
            OFS_OSD_START: osd_start_s = word;
            OFS_OSD_SIZE:  osd_size_s = word;
            default: ;
          endcase
          low_bytes = '0;
        end
      endcase
      pos = pos + 11'd1;
    endfunction

    function void note_item(item_t it);
      result_t r;
      // bytes past the end of the header are dropped
      if (pos < HDR_LEN) take_byte(it.byte_value, it.check_mbr);
      if (!it.last_byte) return;
      r = '0;
      if (pos < HDR_LEN) begin
        r.status = STATUS_INCOMPLETE;
      end else if (magic_seen != magic_word) begin
        r.status = STATUS_NO_MAGIC;
      end else begin
        r.stored_sum       = stored;
        r.computed_sum     = word_sum;
        r.next_sector      = next_s;
        r.previous_sector  = prev_s;
        r.start_sector     = start_s;
        r.length_sectors   = length_s;
        r.part_type        = ptype;
        r.part_flags       = pflags;
        r.sub_count        = sub_s;
        r.osd_start_sector = osd_start_s;
        r.osd_size_sectors = osd_size_s;
        if (stored != word_sum)
          r.status = STATUS_BAD_SUM;
        else if (chk && !(id_ok && sig_ok && start_s == 0 && ptype == mbr_type))
          r.status = STATUS_BAD_MBR;
        else
          r.status = STATUS_VALID;
      end
      expected_q.insert(expected_q.size(), r);
      clear();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
    endtask

    task compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("result item with no header pending");
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("stored_sum", got.stored_sum, want.stored_sum);
      compare_field("computed_sum", got.computed_sum, want.computed_sum);
      compare_field("next_sector", got.next_sector, want.next_sector);
      compare_field("previous_sector", got.previous_sector, want.previous_sector);
      compare_field("start_sector", got.start_sector, want.start_sector);
      compare_field("length_sectors", got.length_sectors, want.length_sectors);
      compare_field("part_type", 32'(got.part_type), 32'(want.part_type));
      compare_field("part_flags", 32'(got.part_flags), 32'(want.part_flags));
      compare_field("sub_count", got.sub_count, want.sub_count);
      compare_field("osd_start_sector", got.osd_start_sector, want.osd_start_sector);
      compare_field("osd_size_sectors", got.osd_size_sectors, want.osd_size_sectors);
    endtask
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata = '0;  // byte_value
  logic                   s_tuser = 1'b0; // check_mbr
  logic                   s_tlast = 1'b0; // last_byte
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // stored_sum, computed_sum, next_sector, previous_sector, start_sector,
  // length_sectors, part_type, part_flags, sub_count, osd_start_sector,
  // osd_size_sectors
  logic [TDATA_W-1:0]     m_tdata;
  logic [TUSER_W-1:0]     m_tuser;  // status

  header_scoreboard board = new();
  item_t            send_q[$];
  int unsigned      items_left = 0;   // queued or on the bus, not yet taken
  int unsigned      holds_req = 0;    // long receiver hold-offs asked for

  partition_header_checker_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // build one header image, fix up magic, mbr content and checksum, apply one
  // flaw by kind, and queue its bytes
  task automatic send_header(hdr_kind_t kind, bit chk, int unsigned short_len,
                             int unsigned extra, fill_t fill);
    logic [7:0]        hdr [HDR_LEN];
    logic [WORD_W-1:0] total;
    int unsigned       len;
    item_t             it;
    for (int i = 0; i < HDR_LEN; i++)
      hdr[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
    {hdr[OFS_MAGIC+3], hdr[OFS_MAGIC+2], hdr[OFS_MAGIC+1], hdr[OFS_MAGIC]} = board.magic_word;
    if (kind inside {HDR_MBR, HDR_BAD_ID, HDR_BAD_SIG, HDR_BAD_START, HDR_BAD_TYPE}) begin
      for (int i = 0; i < ID_BYTES; i++) hdr[OFS_ID+i] = ID_PATTERN[i];
      for (int i = 0; i < SIG_BYTES; i++) hdr[OFS_SIG+i] = SIG_PATTERN[i];
      for (int i = 0; i < 4; i++) hdr[OFS_START+i] = 8'h00;
      {hdr[OFS_TYPE+1], hdr[OFS_TYPE]} = board.mbr_type;
    end
    // single bit flips into the field under test
    case (kind)
      HDR_BAD_MAGIC: hdr[OFS_MAGIC + $urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
      HDR_BAD_ID:    hdr[OFS_ID + $urandom_range(0, ID_BYTES-1)] ^= 8'h01 << $urandom_range(0, 7);
      HDR_BAD_SIG:   hdr[OFS_SIG + $urandom_range(0, SIG_BYTES-1)] ^= 8'h01 << $urandom_range(0, 7);
      HDR_BAD_START: hdr[OFS_START + $urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
      HDR_BAD_TYPE:  hdr[OFS_TYPE + $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
      default: ;
    endcase
    total = '0;
    for (int w = 1; w < HDR_LEN/4; w++)
      total = total + {hdr[4*w+3], hdr[4*w+2], hdr[4*w+1], hdr[4*w]};
    {hdr[3], hdr[2], hdr[1], hdr[0]} = total;
    if (kind == HDR_BAD_SUM) hdr[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);

    len = (kind == HDR_SHORT) ? short_len : HDR_LEN + extra;
    for (int i = 0; i < len; i++) begin
      it.byte_value = (i < HDR_LEN) ? hdr[i] : 8'($urandom);
      // check_mbr only counts on the first byte, noise elsewhere
      it.check_mbr  = (i == 0) ? chk : 1'($urandom);
      it.last_byte  = (i == len - 1);
      send_q.insert(send_q.size(), it);
      items_left++;
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
  endtask

  // sender pause: everything taken, every result back, block settled
  task automatic wait_drained();
    while (items_left != 0 || board.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // header bytes, sent in bursts with random gaps
  initial begin : byte_sender
    item_t       cur;
    bit          taken;
    int unsigned burst_left, gap_left;
    cur = '0;
    burst_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      taken = s_tvalid && s_tready;
      if (taken) begin
        board.note_item(cur);
        items_left--;
      end
      @(negedge clk);
      if (!s_tvalid || taken) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 200);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (send_q.size() > 0) begin
          cur = send_q.pop_front();
          burst_left--;
          s_tvalid <= 1'b1;
          s_tdata  <= cur.byte_value;
          s_tuser  <= cur.check_mbr;
          s_tlast  <= cur.last_byte;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure: free running, coin toss or mostly stalled,
  // plus long hold-offs on request
  initial begin : result_receiver
    rx_mode_t    mode;
    int unsigned mode_left, hold_left, holds_done;
    mode = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (holds_done != holds_req) begin
        holds_done++;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          RX_FREE: m_tready <= 1'b1;
          RX_COIN: m_tready <= 1'($urandom);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : result_monitor
    result_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.status           = status_t'(m_tuser);
        got.stored_sum       = m_tdata[31:0];
        got.computed_sum     = m_tdata[63:32];
        got.next_sector      = m_tdata[95:64];
        got.previous_sector  = m_tdata[127:96];
        got.start_sector     = m_tdata[159:128];
        got.length_sectors   = m_tdata[191:160];
        got.part_type        = m_tdata[207:192];
        got.part_flags       = m_tdata[223:208];
        got.sub_count        = m_tdata[255:224];
        got.osd_start_sector = m_tdata[287:256];
        got.osd_size_sectors = m_tdata[319:288];
        board.check_result(got);
      end
    end
  end

  // ends the run when neither side has moved an item for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL partition_header_checker_core");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: shortest header and a mid-length short one
    send_header(HDR_SHORT, 1'b1, 1, 0, FILL_ONES);
    send_header(HDR_SHORT, 1'b0, 40, 0, FILL_RANDOM);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        // upper bits of the type write are junk that must be dropped
        case (phase)
          1: begin
            write_reg(REG_MAGIC, 32'h0000_0000);
            write_reg(REG_MBR_TYPE, {16'($urandom), 16'h0000});
          end
          2: begin
            write_reg(REG_MAGIC, 32'hFFFF_FFFF);
            write_reg(REG_MBR_TYPE, {16'($urandom), 16'hFFFF});
          end
          3: begin
            write_reg(REG_MAGIC, $urandom);
            write_reg(REG_MBR_TYPE, $urandom);
          end
          default: begin
            write_reg(REG_MAGIC, MAGIC_RESET);
            write_reg(REG_MBR_TYPE, {16'($urandom), MBR_TYPE_RESET});
          end
        endcase
      end

      // one complete mbr header under written registers, with trailing bytes
      if (phase == FULL_PHASE)
        send_header(HDR_MBR, 1'b1, 0, 5, FILL_RANDOM);

      for (int n = 0; n < RANDOM_HEADERS; n++)
        send_header(HDR_SHORT, 1'($urandom), $urandom_range(1, 40), 0, FILL_RANDOM);

      // receiver holds off while short headers keep coming, so the block
      // fills and stalls its input
      if (phase == 2 || phase == 3) begin
        holds_req++;
        for (int n = 0; n < 16; n++)
          send_header(HDR_SHORT, 1'($urandom), $urandom_range(1, 3), 0, FILL_RANDOM);
      end
    end

    wait_drained();
    if (board.fail_count == 0 && board.expected_q.size() == 0)
      $display("PASS partition_header_checker_core");
    else
      $display("FAIL partition_header_checker_core");
    $finish;
  end

endmodule

// File: partition_header_checker_core.f
+incdir+rtl
rtl/phc_pkg.sv
rtl/phc_accum.sv
rtl/phc_out_reg.sv
rtl/partition_header_checker_core.sv
test/partition_header_checker_core_test.sv
